// ===== hdl/rspc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rspc_pkg
// Shared types and constants for the rotated shape containment core.
// ----------------------------------------------------------------------------
package rspc_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int QUEUE_DEPTH      = 2;
	localparam int REG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 32;
	localparam int DIFF_W           = 33;

	localparam logic [REG_IDX_W-1:0] REG_SHAPE_TYPE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COS_ROT      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SIN_ROT      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_HALF_X       = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_HALF_Y       = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd7;

	localparam logic [1:0] SHAPE_CIRCLE    = 2'd0;
	localparam logic [1:0] SHAPE_ELLIPSE   = 2'd1;
	localparam logic [1:0] SHAPE_RECTANGLE = 2'd2;
	localparam logic [1:0] SHAPE_POLYGON   = 2'd3;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [1:0]         shape_type;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] cos_rot;
		logic signed [31:0] sin_rot;
		logic [30:0]        half_x;
		logic [30:0]        half_y;
		logic [6:0]         vertex_count;
	} cfg_t;

	// load: a/b are the vertex coordinates; query: a/b are the offsets from center
	typedef struct packed {
		logic                     kind;
		logic [5:0]               idx;
		logic signed [DIFF_W-1:0] a;
		logic signed [DIFF_W-1:0] b;
	} item_t;

endpackage
`default_nettype wire

// ===== hdl/rotated_shape_point_containment_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_shape_point_containment_core
// Point-in-shape test (circle, ellipse, rectangle, polygon) after translate
// and rotate; polygon vertices are loaded through the request channel.
// ----------------------------------------------------------------------------
// The engine holds one request at a time; it shares the 34x34 multiplier and
// reads one vertex memory word per polygon edge, and edges that need the exact
// crossing test take extra multiplier steps. Loads are written to vertex memory
// as they leave the queue, while the engine is idle.
// Reset clears control and config registers; vertex memory is not cleared.
// ----------------------------------------------------------------------------
module rotated_shape_point_containment_core #(
	parameter int MAX_VERTICES = rspc_pkg::MAX_VERTICES_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                push,
	output logic                               full,
	input  wire                                kind,
	input  wire [5:0]                          vertex_index,
	input  wire signed [31:0]                  coord_x,
	input  wire signed [31:0]                  coord_y,
	output logic                               empty,
	input  wire                                pop,
	output logic                               inside_res,
	input  wire                                write_en,
	input  wire [rspc_pkg::REG_IDX_W-1:0]      reg_index,
	input  wire [rspc_pkg::CFG_DATA_W-1:0]     write_data
);
	import rspc_pkg::*;

	cfg_t  cfg_q;
	logic  q_wr;
	item_t q_wdata;
	logic  q_full;
	logic  q_empty;
	logic  q_rd;
	item_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_type   <= SHAPE_CIRCLE;
			cfg_q.center_x     <= '0;
			cfg_q.center_y     <= '0;
			cfg_q.cos_rot      <= 32'sd1073741824;
			cfg_q.sin_rot      <= '0;
			cfg_q.half_x       <= 31'd65536;
			cfg_q.half_y       <= 31'd65536;
			cfg_q.vertex_count <= '0;
		end else if (write_en) begin
			case (reg_index)
				REG_SHAPE_TYPE:   cfg_q.shape_type   <= write_data[1:0];
				REG_CENTER_X:     cfg_q.center_x     <= write_data;
				REG_CENTER_Y:     cfg_q.center_y     <= write_data;
				REG_COS_ROT:      cfg_q.cos_rot      <= write_data;
				REG_SIN_ROT:      cfg_q.sin_rot      <= write_data;
				REG_HALF_X:       cfg_q.half_x       <= write_data[30:0];
				REG_HALF_Y:       cfg_q.half_y       <= write_data[30:0];
				REG_VERTEX_COUNT: cfg_q.vertex_count <= write_data[6:0];
				default: ;
			endcase
		end
	end

	rspc_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.vertex_index(vertex_index),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.cfg         (cfg_q),
		.q_wr        (q_wr),
		.q_wdata     (q_wdata),
		.q_full      (q_full)
	);

	rspc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wr_data(q_wdata),
		.rd_en  (q_rd),
		.rd_data(q_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	rspc_back #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.inside_res(inside_res)
	);

endmodule
`default_nettype wire

// ===== hdl/rspc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rspc_front
// Request intake: drops out-of-range loads, offsets queries by the center.
// ----------------------------------------------------------------------------
module rspc_front #(
	parameter int MAX_VERTICES = rspc_pkg::MAX_VERTICES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	output logic                  full,
	input  wire                   kind,
	input  wire [5:0]             vertex_index,
	input  wire signed [31:0]     coord_x,
	input  wire signed [31:0]     coord_y,
	input  wire rspc_pkg::cfg_t   cfg,
	output logic                  q_wr,
	output rspc_pkg::item_t       q_wdata,
	input  wire                   q_full
);
	import rspc_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  take;
	logic  keep;

	assign full    = valid_s1 && q_full;
	assign take    = push && !full;
	assign q_wr    = valid_s1 && !q_full;
	assign q_wdata = item_s1;
	assign keep    = (kind == KIND_QUERY) || ({26'd0, vertex_index} < MAX_VERTICES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= keep;
		end else if (q_wr) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind <= kind;
			item_s1.idx  <= vertex_index;
			if (kind == KIND_QUERY) begin
				item_s1.a <= {coord_x[31], coord_x} - {cfg.center_x[31], cfg.center_x};
				item_s1.b <= {coord_y[31], coord_y} - {cfg.center_y[31], cfg.center_y};
			end else begin
				item_s1.a <= {coord_x[31], coord_x};
				item_s1.b <= {coord_y[31], coord_y};
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rspc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rspc_queue
// Short FIFO between intake and the evaluation engine.
// ----------------------------------------------------------------------------
module rspc_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   wr_en,
	input  wire rspc_pkg::item_t  wr_data,
	input  wire                   rd_en,
	output rspc_pkg::item_t       rd_data,
	output logic                  full,
	output logic                  empty
);
	import rspc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

	item_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !rd_en) |=> (cnt_q == $past(cnt_q)))
		else $error("queue changed level while full and not read");

endmodule
`default_nettype wire

// ===== hdl/rspc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rspc_back
// Evaluation engine: vertex memory, shared multiplier/accumulator sequencer,
// shape tests and the result register.
// ----------------------------------------------------------------------------
module rspc_back #(
	parameter int MAX_VERTICES = rspc_pkg::MAX_VERTICES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire rspc_pkg::cfg_t   cfg,
	input  wire                   q_empty,
	input  wire rspc_pkg::item_t  q_data,
	output logic                  q_rd,
	input  wire                   pop,
	output logic                  empty,
	output logic                  inside_res
);
	import rspc_pkg::*;

	localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW     = $clog2(MAX_VERTICES + 1);
	localparam int OPW    = 34;
	localparam int PROD_W = 2 * OPW;
	localparam int ACC_W  = 128;
	localparam int XW     = 36;

	localparam logic [3:0] CIRC_LAST = 4'd4;
	localparam logic [3:0] ROT_XSTEP = 4'd3;
	localparam logic [3:0] ROT_LAST  = 4'd5;
	localparam logic [3:0] ELL_LAST  = 4'd13;
	localparam logic [3:0] PMUL_LAST = 4'd3;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_ROT    = 10'b0000000010,
		ST_CIRC   = 10'b0000000100,
		ST_RECT   = 10'b0000001000,
		ST_ELL    = 10'b0000010000,
		ST_PSTART = 10'b0000100000,
		ST_PFIRST = 10'b0001000000,
		ST_PCHK   = 10'b0010000000,
		ST_PMUL   = 10'b0100000000,
		ST_DONE   = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
	typedef enum logic [1:0] {SH_0, SH_32, SH_62} shift_t;

	typedef struct packed {
		acc_op_t op;
		shift_t  sh;
	} acc_cmd_t;

	state_t                   state_q;
	logic [3:0]               step_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [XW-1:0]     x_q, y_q;
	logic [61:0]              sq_q;
	logic signed [PROD_W-1:0] prod_s1;
	acc_cmd_t                 cmd_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     res_q;
	logic signed [31:0]       ix_q, iy_q;
	logic signed [31:0]       rdx_q, rdy_q;
	logic [CW-1:0]            j_q;
	logic signed [DIFF_W-1:0] u_q, d_q, w_q, t_q;
	logic                     out_valid_q;
	logic                     out_inside_q;

	logic signed [31:0]       vx_mem [MAX_VERTICES];
	logic signed [31:0]       vy_mem [MAX_VERTICES];

	logic signed [OPW-1:0]    mul_a, mul_b;
	acc_cmd_t                 cmd;
	logic                     sq_latch;
	logic [61:0]              sq_cur;
	logic signed [ACC_W-1:0]  term, term_sh;
	logic                     acc_neg;
	logic [DIFF_W-1:0]        cux, cuy;
	logic [XW-1:0]            rux, ruy;
	logic                     circ_fail, ell_fail, rect_in;
	logic [CW-1:0]            n_w, nm1, j_nx;
	logic                     mem_we, mem_re;
	logic [AW-1:0]            mem_ra;
	logic                     out_load;

	logic signed [XW-1:0]     iy_w, jy_w, lo_w, hi_w, ay_w, ax_w, tt_w, uu_w;
	logic signed [31:0]       ax, ay, bx, by;
	logic                     crossing, left, right, ord;
	logic signed [DIFF_W-1:0] d_w, w_w;

	assign sq_cur  = sq_latch ? prod_s1[61:0] : sq_q;
	assign acc_neg = acc_q[ACC_W-1];

	assign cux = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
	assign cuy = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
	assign rux = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
	assign ruy = y_q[XW-1] ? XW'(-y_q) : XW'(y_q);

	assign circ_fail = (cux >= DIFF_W'(cfg.half_x)) || (cuy >= DIFF_W'(cfg.half_x));
	assign ell_fail  = (rux >= XW'(cfg.half_x)) || (ruy >= XW'(cfg.half_y));
	assign rect_in   = (rux < XW'(cfg.half_x)) && (ruy < XW'(cfg.half_y));

	assign n_w  = ({25'd0, cfg.vertex_count} > MAX_VERTICES) ? CW'(MAX_VERTICES)
	                                                         : CW'(cfg.vertex_count);
	assign nm1  = n_w - CW'(1);
	assign j_nx = j_q + CW'(1);

	// edge geometry, previous vertex in ix/iy, current in rdx/rdy
	assign iy_w     = XW'(iy_q);
	assign jy_w     = XW'(rdy_q);
	assign crossing = (iy_w > y_q) != (jy_w > y_q);
	assign ord      = iy_q < rdy_q;
	assign ax       = ord ? ix_q : rdx_q;
	assign ay       = ord ? iy_q : rdy_q;
	assign bx       = ord ? rdx_q : ix_q;
	assign by       = ord ? rdy_q : iy_q;
	assign ax_w     = XW'(ax);
	assign ay_w     = XW'(ay);
	assign lo_w     = (ax < bx) ? XW'(ax) : XW'(bx);
	assign hi_w     = (ax < bx) ? XW'(bx) : XW'(ax);
	assign left     = x_q < lo_w;
	assign right    = x_q >= hi_w;
	assign d_w      = DIFF_W'(by) - DIFF_W'(ay);
	assign w_w      = DIFF_W'(bx) - DIFF_W'(ax);
	assign tt_w     = y_q - ay_w;
	assign uu_w     = x_q - ax_w;

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		cmd.op   = ACC_NONE;
		cmd.sh   = SH_0;
		sq_latch = 1'b0;
		case (state_q)
			ST_CIRC: begin
				case (step_q)
					4'd0: begin
						mul_a  = OPW'(cux[30:0]);
						mul_b  = OPW'(cux[30:0]);
						cmd.op = ACC_LOAD;
					end
					4'd1: begin
						mul_a  = OPW'(cuy[30:0]);
						mul_b  = OPW'(cuy[30:0]);
						cmd.op = ACC_ADD;
					end
					4'd2: begin
						mul_a  = OPW'(cfg.half_x);
						mul_b  = OPW'(cfg.half_x);
						cmd.op = ACC_SUB;
					end
					default: ;
				endcase
			end
			ST_ROT: begin
				case (step_q)
					4'd0: begin
						mul_a  = OPW'(dx_q);
						mul_b  = OPW'($signed(cfg.cos_rot));
						cmd.op = ACC_LOAD;
					end
					4'd1: begin
						mul_a  = OPW'(dy_q);
						mul_b  = OPW'($signed(cfg.sin_rot));
						cmd.op = ACC_ADD;
					end
					4'd2: begin
						mul_a  = OPW'(dy_q);
						mul_b  = OPW'($signed(cfg.cos_rot));
						cmd.op = ACC_LOAD;
					end
					4'd3: begin
						mul_a  = OPW'(dx_q);
						mul_b  = OPW'($signed(cfg.sin_rot));
						cmd.op = ACC_SUB;
					end
					default: ;
				endcase
			end
			ST_ELL: begin
				// squares of 62-bit terms split into 31-bit halves
				case (step_q)
					4'd0: begin
						mul_a = OPW'(rux[30:0]);
						mul_b = OPW'(cfg.half_y);
					end
					4'd1, 4'd5, 4'd9: begin
						sq_latch = 1'b1;
						mul_a    = OPW'(sq_cur[61:31]);
						mul_b    = OPW'(sq_cur[61:31]);
						cmd.op   = (step_q == 4'd9) ? ACC_SUB : ((step_q == 4'd1) ? ACC_LOAD : ACC_ADD);
						cmd.sh   = SH_62;
					end
					4'd2, 4'd6, 4'd10: begin
						mul_a  = OPW'(sq_cur[61:31]);
						mul_b  = OPW'(sq_cur[30:0]);
						cmd.op = (step_q == 4'd10) ? ACC_SUB : ACC_ADD;
						cmd.sh = SH_32;
					end
					4'd3, 4'd7, 4'd11: begin
						mul_a  = OPW'(sq_cur[30:0]);
						mul_b  = OPW'(sq_cur[30:0]);
						cmd.op = (step_q == 4'd11) ? ACC_SUB : ACC_ADD;
					end
					4'd4: begin
						mul_a = OPW'(ruy[30:0]);
						mul_b = OPW'(cfg.half_x);
					end
					4'd8: begin
						mul_a = OPW'(cfg.half_x);
						mul_b = OPW'(cfg.half_y);
					end
					default: ;
				endcase
			end
			ST_PMUL: begin
				case (step_q)
					4'd0: begin
						mul_a  = OPW'(u_q);
						mul_b  = OPW'(d_q);
						cmd.op = ACC_LOAD;
					end
					4'd1: begin
						mul_a  = OPW'(w_q);
						mul_b  = OPW'(t_q);
						cmd.op = ACC_SUB;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		term = ACC_W'(prod_s1);
		case (cmd_s1.sh)
			SH_32:   term_sh = term <<< 32;
			SH_62:   term_sh = term <<< 62;
			default: term_sh = term;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1.op <= ACC_NONE;
			cmd_s1.sh <= SH_0;
		end else begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(mul_a * mul_b);
		if (sq_latch) begin
			sq_q <= prod_s1[61:0];
		end
		case (cmd_s1.op)
			ACC_LOAD: acc_q <= term_sh;
			ACC_ADD:  acc_q <= acc_q + term_sh;
			ACC_SUB:  acc_q <= acc_q - term_sh;
			default:  ;
		endcase
	end

	// vertex memory
	assign q_rd   = (state_q == ST_IDLE) && !q_empty;
	assign mem_we = q_rd && (q_data.kind == KIND_LOAD);

	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		case (state_q)
			ST_PSTART: begin
				mem_re = (n_w != '0);
				mem_ra = AW'(nm1);
			end
			ST_PFIRST: begin
				mem_re = 1'b1;
				mem_ra = '0;
			end
			ST_PCHK: begin
				mem_re = (j_nx != n_w);
				mem_ra = AW'(j_nx);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vx_mem[AW'(q_data.idx)] <= q_data.a[31:0];
			vy_mem[AW'(q_data.idx)] <= q_data.b[31:0];
		end
		if (mem_re) begin
			rdx_q <= vx_mem[mem_ra];
			rdy_q <= vy_mem[mem_ra];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (q_rd && (q_data.kind == KIND_QUERY)) begin
						state_q <= (cfg.shape_type == SHAPE_CIRCLE) ? ST_CIRC : ST_ROT;
					end
				end
				ST_CIRC: begin
					step_q <= step_q + 4'd1;
					if ((step_q == 4'd0 && circ_fail) || step_q == CIRC_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_ROT: begin
					step_q <= step_q + 4'd1;
					if (step_q == ROT_LAST) begin
						step_q <= '0;
						case (cfg.shape_type)
							SHAPE_ELLIPSE:   state_q <= ST_ELL;
							SHAPE_RECTANGLE: state_q <= ST_RECT;
							default:         state_q <= ST_PSTART;
						endcase
					end
				end
				ST_RECT: state_q <= ST_DONE;
				ST_ELL: begin
					step_q <= step_q + 4'd1;
					if ((step_q == 4'd0 && ell_fail) || step_q == ELL_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_PSTART: begin
					j_q     <= '0;
					state_q <= (n_w == '0) ? ST_DONE : ST_PFIRST;
				end
				ST_PFIRST: state_q <= ST_PCHK;
				ST_PCHK: begin
					j_q    <= j_nx;
					step_q <= '0;
					if (crossing && !left && !right) begin
						state_q <= ST_PMUL;
					end else if (j_nx == n_w) begin
						state_q <= ST_DONE;
					end
				end
				ST_PMUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == PMUL_LAST) begin
						state_q <= (j_q == n_w) ? ST_DONE : ST_PCHK;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || pop) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_rd) begin
					dx_q <= q_data.a;
					dy_q <= q_data.b;
				end
			end
			ST_CIRC: begin
				if (step_q == 4'd0 && circ_fail) begin
					res_q <= 1'b0;
				end else if (step_q == CIRC_LAST) begin
					res_q <= acc_neg;
				end
			end
			ST_ROT: begin
				if (step_q == ROT_XSTEP) begin
					x_q <= acc_q[XW+29:30];
				end
				if (step_q == ROT_LAST) begin
					y_q <= acc_q[XW+29:30];
				end
			end
			ST_RECT: res_q <= rect_in;
			ST_ELL: begin
				if (step_q == 4'd0 && ell_fail) begin
					res_q <= 1'b0;
				end else if (step_q == ELL_LAST) begin
					res_q <= acc_neg;
				end
			end
			ST_PSTART: res_q <= 1'b0;
			ST_PFIRST: begin
				ix_q <= rdx_q;
				iy_q <= rdy_q;
			end
			ST_PCHK: begin
				ix_q <= rdx_q;
				iy_q <= rdy_q;
				u_q  <= DIFF_W'(uu_w);
				d_q  <= d_w;
				w_q  <= w_w;
				t_q  <= DIFF_W'(tt_w);
				if (crossing && left) begin
					res_q <= !res_q;
				end
			end
			ST_PMUL: begin
				if (step_q == PMUL_LAST && acc_neg) begin
					res_q <= !res_q;
				end
			end
			default: ;
		endcase
	end

	// result register
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || pop);
	assign empty      = !out_valid_q;
	assign inside_res = out_inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_inside_q <= res_q;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(out_inside_q)))
		else $error("pending result changed before pop");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PCHK) |-> ((j_q < n_w) && (n_w != '0)))
		else $error("edge walk index out of range");

	a_ell_entry: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ELL) && ($past(state_q) != ST_ELL)) |-> ($past(state_q) == ST_ROT))
		else $error("ellipse test entered without rotation");

endmodule
`default_nettype wire

// ===== test/tb_rotated_shape_point_containment_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotated_shape_point_containment_core
// Self-checking bench for the rotated shape containment core. Random vertex loads
// and a directed table run first, then random phases over all shapes with translated
// and rotated frames. Answers are checked against the table or a local containment predictor.
// ----------------------------------------------------------------------------
module tb_rotated_shape_point_containment_core;
	import rspc_pkg::*;

	localparam int NPH       = 16;
	localparam int PER_PHASE = 46;
	localparam int SETTLE    = 400;
	localparam int WD_LIMIT  = 6000;

	typedef struct {
		logic               kind;
		logic [5:0]         idx;
		logic signed [31:0] x;
		logic signed [31:0] y;
		bit                 known;
		bit                 want_in;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic kind = KIND_LOAD;
	logic [5:0] vertex_index = '0;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic pop = 1'b0;
	logic write_en = 1'b0;
	logic [REG_IDX_W-1:0] reg_index = REG_SHAPE_TYPE;
	logic [CFG_DATA_W-1:0] write_data = '0;
	wire full, empty, inside_res;

	rotated_shape_point_containment_core u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.vertex_index(vertex_index), .coord_x(coord_x), .coord_y(coord_y),
		.empty(empty), .pop(pop), .inside_res(inside_res),
		.write_en(write_en), .reg_index(reg_index), .write_data(write_data)
	);

	// shadow of the configured shape and vertex memory
	logic [1:0]         sh_type;
	logic signed [31:0] sh_cx, sh_cy, sh_cos, sh_sin;
	logic [30:0]        sh_hx, sh_hy;
	logic [6:0]         sh_cnt;
	logic signed [31:0] vtx_x [64];
	logic signed [31:0] vtx_y [64];

	bit inside_q[$];
	bit stall_on = 1'b1;
	int mismatches = 0, checked = 0, queries = 0, loads = 0;

	dir_row_t dir_rows [13] = '{
		'{KIND_QUERY, 6'd0,  32'sd0,        32'sd0,        1'b1, 1'b1},
		'{KIND_QUERY, 6'd63, 32'sd65535,    32'sd0,        1'b1, 1'b1},
		'{KIND_QUERY, 6'd0,  32'sd0,        -32'sd65535,   1'b1, 1'b1},
		'{KIND_QUERY, 6'd0,  32'sd65536,    32'sd0,        1'b1, 1'b0},
		'{KIND_QUERY, 6'd0,  32'sd0,        -32'sd65536,   1'b1, 1'b0},
		'{KIND_QUERY, 6'd0,  32'sd46340,    32'sd46340,    1'b1, 1'b1},
		'{KIND_QUERY, 6'd0,  32'h7fffffff,  32'h7fffffff,  1'b1, 1'b0},
		'{KIND_QUERY, 6'd0,  32'h80000000,  32'h80000000,  1'b1, 1'b0},
		'{KIND_QUERY, 6'd0,  32'h80000000,  32'h7fffffff,  1'b1, 1'b0},
		'{KIND_LOAD,  6'd63, 32'h7fffffff,  32'h80000000,  1'b0, 1'b0},
		'{KIND_LOAD,  6'd0,  32'h80000000,  32'h7fffffff,  1'b0, 1'b0},
		'{KIND_QUERY, 6'd21, -32'sd30000,   32'sd50000,    1'b0, 1'b0},
		'{KIND_QUERY, 6'd42, 32'sd70000,    32'sd1,        1'b0, 1'b0}
	};

	function automatic bit contains_point(logic signed [31:0] qx, logic signed [31:0] qy);
		longint dx0, dy0;
		logic signed [127:0] dx, dy, px, py, ux, uy, hx, hy, cs, sn;
		logic signed [127:0] ax, ay, bx, by, ix, iy, jx, jy, lo, hi;
		int n, i;
		bit c;
		dx0 = longint'(qx) - longint'(sh_cx);
		dy0 = longint'(qy) - longint'(sh_cy);
		dx = dx0;
		dy = dy0;
		hx = {97'd0, sh_hx};
		hy = {97'd0, sh_hy};
		cs = sh_cos;
		sn = sh_sin;
		if (sh_type == SHAPE_CIRCLE) begin
			ux = dx < 0 ? -dx : dx;
			uy = dy < 0 ? -dy : dy;
			return ux < hx && uy < hx && ux * ux + uy * uy < hx * hx;
		end
		px = (dx * cs + dy * sn) >>> 30;
		py = (dy * cs - dx * sn) >>> 30;
		ux = px < 0 ? -px : px;
		uy = py < 0 ? -py : py;
		if (sh_type == SHAPE_ELLIPSE)
			return ux < hx && uy < hy &&
				ux * ux * hy * hy + uy * uy * hx * hx < hx * hx * hy * hy;
		if (sh_type == SHAPE_RECTANGLE)
			return ux < hx && uy < hy;
		n = sh_cnt > 64 ? 64 : sh_cnt;
		c = 1'b0;
		for (i = 0; i < n; i++) begin
			ix = vtx_x[i == 0 ? n - 1 : i - 1];
			iy = vtx_y[i == 0 ? n - 1 : i - 1];
			jx = vtx_x[i];
			jy = vtx_y[i];
			if ((iy > py) != (jy > py)) begin
				if (iy < jy) begin
					ax = ix; ay = iy; bx = jx; by = jy;
				end else begin
					ax = jx; ay = jy; bx = ix; by = iy;
				end
				lo = ax < bx ? ax : bx;
				hi = ax < bx ? bx : ax;
				if (px < lo)
					c = !c;
				else if (px < hi && (px - ax) * (by - ay) < (bx - ax) * (py - ay))
					c = !c;
			end
		end
		return c;
	endfunction

	initial forever #5 clk = ~clk;

	// one request; leaves push high after acceptance
	task automatic send_req(logic k, logic [5:0] idx, logic signed [31:0] x,
			logic signed [31:0] y, bit known, bit want);
		bit ok;
		if (stall_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		vertex_index <= idx;
		coord_x <= x;
		coord_y <= y;
		do begin
			@(negedge clk);
			ok = !full;
			@(posedge clk);
		end while (!ok);
		if (k == KIND_LOAD) begin
			vtx_x[idx] = x;
			vtx_y[idx] = y;
			loads++;
		end else begin
			inside_q.push_back(known ? want : contains_point(x, y));
			queries++;
		end
	endtask

	task automatic drain_idle();
		push <= 1'b0;
		while (inside_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_shape(logic [1:0] st, logic signed [31:0] cx, logic signed [31:0] cy,
			logic signed [31:0] cs, logic signed [31:0] sn, logic [30:0] hx,
			logic [30:0] hy, logic [6:0] cnt);
		logic [CFG_DATA_W-1:0] vals [8];
		int r;
		vals = '{{30'd0, st}, cx, cy, cs, sn, {1'b0, hx}, {1'b0, hy}, {25'd0, cnt}};
		for (r = 0; r < 8; r++) begin
			write_en <= 1'b1;
			reg_index <= REG_IDX_W'(r);
			write_data <= vals[r];
			@(posedge clk);
		end
		write_en <= 1'b0;
		sh_type = st; sh_cx = cx; sh_cy = cy; sh_cos = cs; sh_sin = sn;
		sh_hx = hx; sh_hy = hy; sh_cnt = cnt;
	endtask

	function automatic logic signed [31:0] near(logic signed [31:0] base, int unsigned s);
		longint off;
		off = longint'($urandom_range(0, 2 * s)) - longint'(s);
		return 32'(longint'(base) + off);
	endfunction

	// result side
	initial begin
		bit got, val, want;
		@(posedge arst_n);
		forever begin
			if (stall_on && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			pop <= 1'b1;
			@(negedge clk);
			got = !empty;
			val = inside_res;
			@(posedge clk);
			if (got) begin
				checked++;
				if (inside_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result inside_res=%0b at %0t", val, $realtime);
				end else begin
					want = inside_q.pop_front();
					if (val !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("inside_res mismatch: exp %0b got %0b at %0t",
								want, val, $realtime);
					end
				end
			end
		end
	end

	// watchdog on cycles with no request, result or write
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(negedge clk);
			if ((push && !full) || (pop && !empty) || write_en || !arst_n)
				quiet = 0;
			else
				quiet++;
			if (quiet >= WD_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int ph, it, r, n, nv, span;
		logic [1:0] st;
		logic signed [31:0] cx, cy, cs, sn;
		logic [30:0] hx, hy;
		logic [6:0] cnt;
		real ang, rad;
		sh_type = SHAPE_CIRCLE; sh_cx = 0; sh_cy = 0;
		sh_cos = 32'sd1073741824; sh_sin = 0;
		sh_hx = 31'd65536; sh_hy = 31'd65536; sh_cnt = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (r = 0; r < 64; r++)
			send_req(KIND_LOAD, 6'(r), $urandom, $urandom, 1'b0, 1'b0);
		foreach (dir_rows[r])
			send_req(dir_rows[r].kind, dir_rows[r].idx, dir_rows[r].x, dir_rows[r].y,
				dir_rows[r].known, dir_rows[r].want_in);
		for (ph = 0; ph < NPH; ph++) begin
			drain_idle();
			stall_on = ph < NPH - 2;
			st = 2'(ph % 4);
			span = $urandom_range(1 << 12, 1 << 22);
			cx = $urandom_range(0, 3) == 0 ? $urandom : near(0, 1 << 28);
			cy = $urandom_range(0, 3) == 0 ? $urandom : near(0, 1 << 28);
			ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
			cs = $rtoi($cos(ang) * 1073741824.0);
			sn = $rtoi($sin(ang) * 1073741824.0);
			hx = 31'($urandom_range(span / 4, span));
			hy = 31'($urandom_range(span / 4, span));
			cnt = 7'($urandom_range(3, 12));
			case (ph)
				0: begin cx = 32'h7fffffff; cy = 32'h80000000; end
				1: begin cs = -32'sd1073741824; sn = 32'sd1073741824; end
				2: begin
					cs = 32'sd1073741824; sn = -32'sd1073741824;
					hx = 31'h7fffffff; span = 1 << 30;
				end
				3: cnt = 7'd64;
				4: hx = 31'd0;
				5: hx = 31'd0;
				6: hy = 31'd0;
				7: cnt = 7'd0;
				9: begin cx = 32'h80000000; cy = 32'h7fffffff; end
				10: begin cs = $urandom; sn = $urandom; end
				11: cnt = 7'd100;
				15: cnt = 7'($urandom_range(1, 2));
				default: ;
			endcase
			write_shape(st, cx, cy, cs, sn, hx, hy, cnt);
			nv = 0;
			if (st == SHAPE_POLYGON) begin
				n = cnt > 64 ? 64 : cnt;
				nv = n == 0 ? 4 : n;
				for (r = 0; r < nv; r++) begin
					ang = (r + $urandom_range(0, 40) / 100.0) * 6.28318530718 / nv;
					rad = span * ($urandom_range(50, 100) / 100.0);
					send_req(KIND_LOAD, 6'(r), $rtoi(rad * $cos(ang)),
						$rtoi(rad * $sin(ang)), 1'b0, 1'b0);
				end
			end
			for (it = 0; it < PER_PHASE - nv / 2; it++) begin
				if (ph == 8 && it == 20) begin
					push <= 1'b0;
					while (inside_q.size() != 0) @(posedge clk);
				end
				r = $urandom_range(0, 9);
				if (st == SHAPE_POLYGON && r == 0)
					send_req(KIND_LOAD, 6'($urandom), near(0, span), near(0, span),
						1'b0, 1'b0);
				else if (r == 1)
					send_req(KIND_QUERY, 6'($urandom), $urandom, $urandom, 1'b0, 1'b0);
				else
					send_req(KIND_QUERY, 6'($urandom), near(cx, 2 * span),
						near(cy, 2 * span), 1'b0, 1'b0);
			end
		end
		push <= 1'b0;
		while (inside_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d shape phases: %0d point queries, %0d vertex loads",
			NPH, queries, loads);
		$display("%0d answers checked, %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
